[rtl/core/pat_pkg.sv]
// Shared types and constants for the positional array table.
// No dependencies; compile first.
package pat_pkg;

    localparam int DEPTH    = 64;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;
    localparam int FILL_W   = 7;
    // compare width wide enough for position and count plus one
    localparam int CMP_W    = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR   = 3'd0,
        ACT_APPEND  = 3'd1,
        ACT_DISPLAY = 3'd2,
        ACT_INSERT  = 3'd3,
        ACT_DELETE  = 3'd4,
        ACT_SEARCH  = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DISP_RD,
        S_DISP_OUT
    } state_t;

endpackage

[rtl/core/pat_if.sv]
// Valid/ready channel interfaces for request and result beats.
// Depends on pat_pkg for field widths.
interface pat_req_if;
    import pat_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [POS_W-1:0]           position;
    logic signed [WORD_W-1:0]   value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface pat_rsp_if;
    import pat_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [SLOT_W-1:0]          slot;
    logic signed [WORD_W-1:0]   word;
    logic                       last;
    logic [FILL_W-1:0]          fill;

    modport source (output valid, output status, output slot, output word, output last,
                    output fill, input ready);
    modport sink   (input valid, input status, input slot, input word, input last,
                    input fill, output ready);
endinterface

[rtl/core/positional_array_table.sv]
// Top level of the positional array table: one-port-read, one-port-write entry RAM
// and a sequencer for clear, append, display, insert, delete and search.
// Depends on pat_pkg and the channel interfaces in pat_if.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+----------------------------------
//  req     | in  | valid/ready  | action, position, value
//  rsp     | out | valid/ready  | status, slot, word, last, fill
//
// A request beat is taken only while the sequencer idles; a decode state follows,
// in which clear, append and the error cases finish. Insert and delete shift the
// entries behind p, search scans to a hit or the end, display emits each entry.
// Each shifted or scanned entry takes a read state and a write or use state on
// the RAM, whose read data is registered. A held result beat stalls the sequencer
// only where it must emit another. Reset clears the count; the RAM is not cleared.
module positional_array_table (
    input logic      clk,
    input logic      rst_n,
    pat_req_if.sink  req,
    pat_rsp_if.source rsp
);
    import pat_pkg::*;

    state_t                   state_reg, state_next;
    action_t                  action_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    logic                     wr_en, rd_en;
    logic [AW-1:0]            wr_addr, rd_addr;
    logic signed [WORD_W-1:0] wr_data;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic signed [WORD_W-1:0] out_word_reg;
    logic                     out_last_reg;
    logic [FILL_W-1:0]        out_fill_reg;

    logic                     emit;
    status_t                  e_status;
    logic [SLOT_W-1:0]        e_slot;
    logic signed [WORD_W-1:0] e_word;
    logic                     e_last;

    logic          accept, out_free;
    logic          is_full, is_empty, ins_bad, del_bad, ins_more, del_more;
    logic          srch_hit, at_end;
    logic [CMP_W-1:0] pos_x, cnt_x, idx_x;
    logic [CW-1:0] idx_inc, idx_dec, pos_idx;
    logic [POS_W-1:0] pos_m1;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_x    = CMP_W'(pos_reg);
    assign cnt_x    = CMP_W'(count_reg);
    assign idx_x    = CMP_W'(idx_reg);
    assign ins_bad  = (pos_reg == '0) || (pos_x > cnt_x + CMP_W'(1));
    assign del_bad  = (pos_reg == '0) || (pos_x > cnt_x);
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    assign pos_m1   = pos_reg - POS_W'(1);
    assign pos_idx  = CW'(pos_m1);
    assign ins_more = (idx_x >= pos_x);
    assign del_more = (idx_inc < count_reg);
    assign srch_hit = (rd_data_reg == val_reg);
    assign at_end   = (idx_inc == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (action_reg)
                    ACT_DISPLAY:
                    begin
                        if (!is_empty)
                            state_next = S_DISP_RD;
                        else if (out_free)
                            state_next = S_IDLE;
                    end
                    ACT_INSERT:
                    begin
                        if (!is_full && !ins_bad)
                            state_next = S_INS_RD;
                        else if (out_free)
                            state_next = S_IDLE;
                    end
                    ACT_DELETE:
                    begin
                        if (!is_empty && !del_bad)
                            state_next = S_DEL_RD;
                        else if (out_free)
                            state_next = S_IDLE;
                    end
                    ACT_SEARCH:
                    begin
                        if (!is_empty)
                            state_next = S_SRCH_RD;
                        else if (out_free)
                            state_next = S_IDLE;
                    end
                    default:
                    begin
                        if (out_free)
                            state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (ins_more)
                    state_next = S_INS_WR;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_INS_WR:   state_next = S_INS_RD;
            S_DEL_RD:
            begin
                if (del_more)
                    state_next = S_DEL_WR;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_DEL_WR:   state_next = S_DEL_RD;
            S_SRCH_RD:  state_next = S_SRCH_CMP;
            S_SRCH_CMP:
            begin
                if (!srch_hit && !at_end)
                    state_next = S_SRCH_RD;
                else if (out_free)
                    state_next = S_IDLE;
            end
            S_DISP_RD:  state_next = S_DISP_OUT;
            S_DISP_OUT:
            begin
                if (out_free)
                    state_next = at_end ? S_IDLE : S_DISP_RD;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath, RAM strobes and result beats
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = rd_data_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        emit       = 1'b0;
        e_status   = ST_OK;
        e_slot     = '0;
        e_word     = '0;
        e_last     = 1'b1;
        unique case (state_reg)
            S_EXEC:
            begin
                unique case (action_reg)
                    ACT_CLEAR:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            count_next = '0;
                        end
                    end
                    ACT_APPEND:
                    begin
                        if (out_free)
                        begin
                            emit = 1'b1;
                            if (is_full)
                                e_status = ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = val_reg;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end
                    ACT_DISPLAY:
                    begin
                        idx_next = '0;
                        if (is_empty)
                        begin
                            emit     = out_free;
                            e_status = ST_EMPTY;
                        end
                    end
                    ACT_INSERT:
                    begin
                        idx_next = count_reg;
                        if (is_full)
                        begin
                            emit     = out_free;
                            e_status = ST_FULL;
                        end
                        else if (ins_bad)
                        begin
                            emit     = out_free;
                            e_status = ST_BADPOS;
                        end
                    end
                    ACT_DELETE:
                    begin
                        idx_next = pos_idx;
                        if (is_empty)
                        begin
                            emit     = out_free;
                            e_status = ST_EMPTY;
                        end
                        else if (del_bad)
                        begin
                            emit     = out_free;
                            e_status = ST_BADPOS;
                        end
                    end
                    ACT_SEARCH:
                    begin
                        idx_next = '0;
                        if (is_empty)
                        begin
                            emit     = out_free;
                            e_status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        emit = out_free;
                    end
                endcase
            end
            S_INS_RD:
            begin
                if (ins_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_dec[AW-1:0];
                end
                else if (out_free)
                begin
                    // hole is open: drop the new word in
                    wr_en      = 1'b1;
                    wr_data    = val_reg;
                    count_next = count_reg + CW'(1);
                    emit       = 1'b1;
                end
            end
            S_INS_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_dec;
            end
            S_DEL_RD:
            begin
                if (del_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                end
                else if (out_free)
                begin
                    count_next = count_reg - CW'(1);
                    emit       = 1'b1;
                end
            end
            S_DEL_WR:
            begin
                wr_en    = 1'b1;
                idx_next = idx_inc;
            end
            S_SRCH_RD:
            begin
                rd_en = 1'b1;
            end
            S_SRCH_CMP:
            begin
                if (srch_hit)
                begin
                    emit   = out_free;
                    e_slot = SLOT_W'(idx_inc);
                end
                else if (at_end)
                begin
                    emit     = out_free;
                    e_status = ST_NOTFOUND;
                end
                else
                    idx_next = idx_inc;
            end
            S_DISP_RD:
            begin
                rd_en = 1'b1;
            end
            S_DISP_OUT:
            begin
                e_slot = SLOT_W'(idx_inc);
                e_word = rd_data_reg;
                e_last = at_end;
                if (out_free)
                begin
                    emit     = 1'b1;
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            action_reg <= action_t'(req.action);
            pos_reg    <= req.position;
            val_reg    <= req.value;
        end
        if (emit)
        begin
            out_status_reg <= e_status;
            out_slot_reg   <= e_slot;
            out_word_reg   <= e_word;
            out_last_reg   <= e_last;
            out_fill_reg   <= FILL_W'(count_next);
        end
    end

    // entry RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.word   = out_word_reg;
    assign rsp.last   = out_last_reg;
    assign rsp.fill   = out_fill_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || rsp.ready))
        else $error("result beat loaded over an untaken one");

    a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("RAM read and write in the same cycle");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final result beat");

    a_count_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !emit |=> $stable(count_reg))
        else $error("fill count moved without a result beat");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (count_reg <= CW'(DEPTH)))
        else $error("fill count beyond table depth");
`endif

endmodule
